FILE: src/integral_image_stream_macros.svh
// Assertion macros used by the integral image stream checker.
`ifndef INTEGRAL_IMAGE_STREAM_MACROS_SVH
`define INTEGRAL_IMAGE_STREAM_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define IIS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define IIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/iis_pkg.sv
// Shared types and constants of the integral image stream block.
`timescale 1ns / 1ps
`default_nettype none

package iis_pkg;

    // Width of a frame size register on the configuration port.
    localparam int CFG_W = 11;

    // Configuration register indexes.
    localparam logic [0:0] CFG_COLS = 1'b0;
    localparam logic [0:0] CFG_ROWS = 1'b1;

    // Field widths.
    localparam int PIX_W   = 8;
    localparam int RUN_W   = 18;
    localparam int AREA_W  = 28;
    localparam int TDATA_W = 32;

endpackage

`default_nettype wire

FILE: src/iis_line_store.sv
// Line store of the previous row's integral values, with write-to-read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module iis_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 28
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] mem_q_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read that meets a write to the same entry takes the new value.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

`default_nettype wire

FILE: src/integral_image_stream.sv
// Top level of the streaming integral image (summed-area table) block.
`timescale 1ns / 1ps
`default_nettype none

// Streaming integral image. Pixels come in raster order on the s_ channel and
// for each one the block returns, on the m_ channel, the sum of all pixels of
// the current frame at or above its row and at or left of its column. The
// block takes one pixel per clock and returns one result per clock as long as
// the downstream side keeps m_tready high; a result passes from the input
// through stage one into the output register before it is offered. That rate
// is set by the line store, a single memory with one read and one write port:
// each pixel reads its column's entry when it is accepted and writes the new
// value back when it leaves stage one, and a read that meets the write of the
// same entry (a one-pixel-wide frame, where every pixel hits column zero) is
// served from the write data. m_tlast marks the last pixel of a row and
// m_tuser the last pixel of a frame. The frame size is set by two registers
// on the write port: a value of zero counts as one and a value above the
// maximum counts as the maximum. They should be written only while no
// transfer is in flight. If the size is lowered in mid-row or mid-frame, a
// counter past the new end counts as sitting at the last position. The line
// store has no reset; every entry is written during row zero before it is
// read unless the frame is widened past row zero, which is not checked.

module integral_image_stream #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [iis_pkg::CFG_W-1:0]     cfg_wdata,
    // Pixel input channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [iis_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
    // Result channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [iis_pkg::TDATA_W-1:0]   m_tdata,   // [27:0] area_sum, [31:28] zero
    output logic                               m_tlast,   // row_end
    output logic                               m_tuser    // [0] frame_end
);

    import iis_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CSZ_W = $clog2(MAX_COLS + 1);
    localparam int RSZ_W = $clog2(MAX_ROWS + 1);
    localparam logic [PIX_W-1:0] PIX_MASK =
        (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

    // Frame size, held already clamped to the legal range.
    logic [CSZ_W-1:0] cols_reg, cols_next;
    logic [RSZ_W-1:0] rows_reg, rows_next;

    // Position and running row sum of the next pixel to arrive.
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RUN_W-1:0] run_reg, run_next;

    // Stage one: line store read is in flight.
    logic             s1_valid_reg, s1_valid_next;
    logic [CW-1:0]    s1_col_reg;
    logic [RUN_W-1:0] s1_run_reg;
    logic             s1_first_row_reg;
    logic             s1_row_end_reg;
    logic             s1_frame_end_reg;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [AREA_W-1:0] m_sum_reg;
    logic              m_last_reg;
    logic              m_user_reg;

    logic              accept;
    logic              out_free;
    logic              s1_adv;
    logic [CW-1:0]     col_eff;
    logic [RW-1:0]     row_eff;
    logic              at_row_end;
    logic              at_frame_end;
    logic [RUN_W-1:0]  run_sum;
    logic [AREA_W-1:0] above;
    logic [AREA_W-1:0] s1_sum;

    // Handshake: stage one moves on when the output register is free or
    // its result is being taken; a new pixel may enter when stage one is empty or moves.
    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // Configuration writes, clamped on the way in.
    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLS: begin
                    if (cfg_wdata == '0) begin
                        cols_next = CSZ_W'(1);
                    end else if (32'(cfg_wdata) > MAX_COLS) begin
                        cols_next = CSZ_W'(MAX_COLS);
                    end else begin
                        cols_next = CSZ_W'(cfg_wdata);
                    end
                end
                CFG_ROWS: begin
                    if (cfg_wdata == '0) begin
                        rows_next = RSZ_W'(1);
                    end else if (32'(cfg_wdata) > MAX_ROWS) begin
                        rows_next = RSZ_W'(MAX_ROWS);
                    end else begin
                        rows_next = RSZ_W'(cfg_wdata);
                    end
                end
                default: begin
                    cols_next = cols_reg;
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    // Position of the arriving pixel; a counter past a lowered size sits at
    // the last position.
    always_comb begin
        if (32'(col_reg) >= 32'(cols_reg)) begin
            col_eff = CW'(cols_reg - CSZ_W'(1));
        end else begin
            col_eff = col_reg;
        end
        if (32'(row_reg) >= 32'(rows_reg)) begin
            row_eff = RW'(rows_reg - RSZ_W'(1));
        end else begin
            row_eff = row_reg;
        end
        at_row_end   = (32'(col_eff) + 32'd1) >= 32'(cols_reg);
        at_frame_end = at_row_end && ((32'(row_eff) + 32'd1) >= 32'(rows_reg));
        run_sum      = run_reg + RUN_W'(s_tdata & PIX_MASK);
    end

    // Counter and running sum update on each input transfer.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        run_next = run_reg;
        if (accept) begin
            if (at_row_end) begin
                col_next = '0;
                run_next = '0;
                row_next = at_frame_end ? '0 : row_eff + RW'(1);
            end else begin
                col_next = col_eff + CW'(1);
                run_next = run_sum;
                row_next = row_eff;
            end
        end
    end

    // The line store is read at the arriving pixel's column and written
    // back from stage one when that stage moves on.
    iis_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (CW),
        .DW    (AREA_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_eff),
        .rd_data (above),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_sum)
    );

    // Row zero of a frame has nothing above it.
    assign s1_sum = s1_first_row_reg ? AREA_W'(s1_run_reg) : above + AREA_W'(s1_run_reg);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg     <= CSZ_W'(MAX_COLS);
            rows_reg     <= RSZ_W'(MAX_ROWS);
            col_reg      <= '0;
            row_reg      <= '0;
            run_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            run_reg      <= run_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg       <= col_eff;
            s1_run_reg       <= run_sum;
            s1_first_row_reg <= (row_eff == '0);
            s1_row_end_reg   <= at_row_end;
            s1_frame_end_reg <= at_frame_end;
        end
        if (s1_adv) begin
            m_sum_reg  <= s1_sum;
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_sum_reg);
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

FILE: src/iis_checker.sv
// Port-level assertion checker for the integral image stream block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "integral_image_stream_macros.svh"

module iis_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [iis_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                        m_tlast,
    input wire logic                        m_tuser
);

    import iis_pkg::*;

    // A stalled result keeps its payload.
    `IIS_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

    // The last pixel of a frame is also the last of its row.
    `IIS_ASSERT(a_frame_row, aclk, aresetn, m_tvalid && m_tuser |-> m_tlast, "frame end without row end")

    // With the output register empty the input side is never blocked.
    `IIS_ASSERT(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

    // Reset empties the result channel.
    `IIS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind integral_image_stream iis_checker u_iis_checker (.*);

`default_nettype wire

FILE: tb/integral_image_stream_tb.sv
// Self-checking testbench for the streaming integral image block.
`timescale 1ns / 1ps

module integral_image_stream_tb;

    import iis_pkg::*;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int RANDOM_PIXELS = 1200;
    // Cycles without any transfer or register write before the run is abandoned.
    localparam int STALL_LIMIT   = 5000;
    // Results trail their pixel through stage one and the output register, so a short drain catches strays.
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_MAX    = 10;

    // One result of the block as the checker sees it.
    typedef struct packed {
        logic [AREA_W-1:0] area_sum;
        logic              row_end;
        logic              frame_end;
    } area_result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [0:0]         cfg_index = CFG_COLS;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata   = '0;     // [7:0] pixel
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;            // [27:0] area_sum, [31:28] zero
    logic               m_tlast;            // row_end
    logic               m_tuser;            // [0] frame_end

    // Pixels waiting for the driver and sums waiting for the block to produce them.
    logic [PIX_W-1:0] pixel_queue [$];
    area_result_t     expected_sums [$];

    // Idle and stall rates in percent; the stimulus process changes them between phases.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_source    = 1'b0;

    int unsigned pixels_in    = 0;
    int unsigned results_out  = 0;
    int unsigned frames_out   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    // Our own copy of the block's state: line store, row accumulator, position
    // counters and the raw register values as last written.
    logic [AREA_W-1:0] line_sums  [MAX_COLS];
    bit                line_valid [MAX_COLS];
    logic [RUN_W-1:0]  row_sum;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [CFG_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  rows_reg;

    integral_image_stream #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .PIXEL_BITS(PIX_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // A size register of zero means one; anything above the maximum means the maximum.
    function automatic int unsigned frame_size(logic [CFG_W-1:0] raw, int unsigned limit);
        if (raw == '0) return 1;
        if (raw > limit) return limit;
        return 32'(raw);
    endfunction

    function automatic void clear_model();
        cols_reg = CFG_W'(MAX_COLS);
        rows_reg = CFG_W'(MAX_ROWS);
        row_sum  = '0;
        col_pos  = 0;
        row_pos  = 0;
        foreach (line_sums[i]) begin
            line_sums[i]  = '0;
            line_valid[i] = 1'b0;
        end
    endfunction

    // Advances the summed-area state by one pixel and returns what the block
    // should produce for it. A counter left past a shrunken frame is pulled back
    // to the last position first, so that pixel closes the row or the frame.
    function automatic area_result_t integrate_pixel(logic [PIX_W-1:0] pix);
        int unsigned       ncols;
        int unsigned       nrows;
        logic [AREA_W-1:0] above;
        area_result_t      res;
        ncols = frame_size(cols_reg, MAX_COLS);
        nrows = frame_size(rows_reg, MAX_ROWS);
        if (col_pos >= ncols) col_pos = ncols - 1;
        if (row_pos >= nrows) row_pos = nrows - 1;
        row_sum = row_sum + RUN_W'(pix);
        // The top row of a frame has nothing above it.
        above = (row_pos != 0) ? line_sums[col_pos] : '0;
        res.area_sum = above + AREA_W'(row_sum);
        line_sums[col_pos]  = res.area_sum;
        line_valid[col_pos] = 1'b1;
        res.row_end   = (col_pos + 1 >= ncols);
        res.frame_end = res.row_end && (row_pos + 1 >= nrows);
        if (res.row_end) begin
            col_pos = 0;
            row_sum = '0;
            row_pos = res.frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // A new size must never make the block read a line store entry that was never
    // written. That can only happen when the frame is widened while the current
    // position is below the top row.
    function automatic bit resize_is_safe(logic [CFG_W-1:0] new_cols, logic [CFG_W-1:0] new_rows);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned row_next;
        ncols    = frame_size(new_cols, MAX_COLS);
        nrows    = frame_size(new_rows, MAX_ROWS);
        row_next = (row_pos >= nrows) ? nrows - 1 : row_pos;
        if (row_next == 0) return 1'b1;
        for (int c = 0; c < ncols; c++) begin
            if (!line_valid[c]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly uniform values, with the dark and full-scale extremes boosted.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Pixel driver. A new pixel is offered only once the previous one has been
    // transferred, so tvalid never drops while a transfer is pending.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_queue.size() != 0 && !hold_source && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Downstream backpressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every accepted pixel is run through the predictor; every result transfer is
    // checked against the oldest expected sum. The expectation is queued first so
    // that a stray result shows up as a mismatch rather than being missed.
    always @(posedge aclk) begin : check
        area_result_t want;
        logic         bad;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_sums.insert(expected_sums.size(), integrate_pixel(s_tdata));
                pixels_in++;
            end
            if (m_tvalid && m_tready) begin
                results_out++;
                if (m_tuser) frames_out++;
                if (expected_sums.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result %0d: sum %0d last %0b user %0b",
                                 results_out, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = expected_sums.pop_front();
                    bad  = (m_tdata !== TDATA_W'(want.area_sum)) ||
                           (m_tlast !== want.row_end) || (m_tuser !== want.frame_end);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch at result %0d: expected sum %0d last %0b user %0b, got sum %0d last %0b user %0b",
                                     results_out, want.area_sum, want.row_end, want.frame_end,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Returns once every queued pixel has been transferred and every result checked.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_tvalid || expected_sums.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] value);
        if (idx == CFG_COLS) cols_reg = value;
        else rows_reg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Frame size changes only happen with nothing in flight.
    task automatic resize(logic [CFG_W-1:0] ncols, logic [CFG_W-1:0] nrows);
        wait_idle();
        write_reg(CFG_COLS, ncols);
        write_reg(CFG_ROWS, nrows);
    endtask

    task automatic send_pixels(int unsigned n);
        repeat (n) pixel_queue.insert(pixel_queue.size(), rand_pixel());
    endtask

    initial begin : stimulus
        int unsigned      sent;
        int unsigned      iter;
        int unsigned      frame_len;
        int unsigned      count;
        int unsigned      pick;
        logic [CFG_W-1:0] want_cols;
        logic [CFG_W-1:0] want_rows;
        sent = 0;
        iter = 0;
        clear_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // A 3x2 frame at full scale.
        resize(CFG_W'(3), CFG_W'(2));
        repeat (6) pixel_queue.insert(pixel_queue.size(), '1);
        // A zero width counts as one: a one-pixel-wide column of three
        // rows, where each line store read meets the write of the pixel before.
        resize('0, CFG_W'(3));
        pixel_queue.insert(pixel_queue.size(), '1);
        pixel_queue.insert(pixel_queue.size(), '0);
        pixel_queue.insert(pixel_queue.size(), '1);
        // Both sizes far above the maximum, so they clamp; part of a row only.
        resize('1, '1);
        repeat (4) pixel_queue.insert(pixel_queue.size(), '1);
        // Shrink mid-row: the column counter sits past the new width, so the
        // next pixel closes the row and, with a single row, the frame.
        resize(CFG_W'(3), CFG_W'(1));
        pixel_queue.insert(pixel_queue.size(), 8'h80);
        pixel_queue.insert(pixel_queue.size(), 8'h7F);
        // Exact maximum sizes, then narrow to two columns and four rows mid-row.
        resize(CFG_W'(MAX_COLS), CFG_W'(MAX_ROWS));
        pixel_queue.insert(pixel_queue.size(), '1);
        resize(CFG_W'(2), CFG_W'(4));
        repeat (5) pixel_queue.insert(pixel_queue.size(), '1);
        // Shrink the height mid-frame: the row counter clamps to the last row.
        resize(CFG_W'(2), CFG_W'(2));
        repeat (2) pixel_queue.insert(pixel_queue.size(), '0);

        // Random frames. Mostly whole frames of small sizes; now and then only a
        // piece of one, so the next size change lands mid-row or mid-frame.
        while (sent < RANDOM_PIXELS) begin
            wait_idle();
            case ((iter / 6) % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase

            pick = $urandom_range(99);
            if (pick < 60) want_cols = CFG_W'($urandom_range(1, 12));
            else if (pick < 80) want_cols = CFG_W'($urandom_range(13, 40));
            else if (pick < 88) want_cols = '0;
            else if (pick < 94) want_cols = CFG_W'(1);
            else want_cols = CFG_W'($urandom_range(MAX_COLS, 2047));
            pick = $urandom_range(99);
            if (pick < 70) want_rows = CFG_W'($urandom_range(1, 6));
            else if (pick < 80) want_rows = '0;
            else if (pick < 92) want_rows = CFG_W'($urandom_range(7, 16));
            else want_rows = CFG_W'($urandom_range(MAX_ROWS, 2047));
            // Fall back to the current sizes when widening would expose an
            // unwritten line store entry.
            if (!resize_is_safe(want_cols, want_rows)) want_cols = cols_reg;
            if (!resize_is_safe(want_cols, want_rows)) want_rows = rows_reg;
            resize(want_cols, want_rows);

            frame_len = frame_size(cols_reg, MAX_COLS) * frame_size(rows_reg, MAX_ROWS);
            if (frame_len > 300 || (frame_len > 1 && $urandom_range(3) == 0))
                count = $urandom_range(1, (frame_len > 40) ? 40 : frame_len - 1);
            else
                count = frame_len;
            send_pixels(count);
            sent += count;

            // Once, hold the source in the middle of a frame until the block has
            // handed back every result it owes.
            if (iter == 12) begin
                while (pixel_queue.size() > count / 2) @(negedge aclk);
                hold_source = 1'b1;
                while (s_tvalid || expected_sums.size() != 0) @(negedge aclk);
                hold_source = 1'b0;
            end
            iter++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d results for %0d pixels, %0d frames closed, over %0d random size settings,",
                 results_out, pixels_in, frames_out, iter);
        $display("including clamped sizes, mid-row and mid-frame shrinks, and four idle patterns.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
